// ===== src/awa_pkg.sv =====
// Shared constants, character codes and elaboration helpers for the ADC window
// average reporter. No dependencies; imported by every module of the block.
package awa_pkg;

    // Default configuration of the block.
    localparam int WINDOW_DEF          = 5;
    localparam int ADC_BITS_DEF        = 12;
    localparam int FRACTION_DIGITS_DEF = 2;
    localparam int QUEUE_DEPTH_DEF     = 4;

    // Fixed field widths of the stream ports.
    localparam int SAMPLE_PORT_W = 12;
    localparam int S_TDATA_W     = 16;
    localparam int OUT_CHAR_W    = 7;
    localparam int M_TDATA_W     = 8;

    // Full-scale register.
    localparam int          FS_W     = 10;
    localparam logic [9:0]  FS_RESET = 10'd40;
    localparam logic [9:0]  FS_MAX   = 10'd999;

    // The clamped full scale keeps the integer part to three digits.
    localparam int INT_DIGITS = 3;

    // ASCII codes used by the report.
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_POINT = 7'h2E;
    localparam logic [6:0] CH_LF    = 7'h0A;
    localparam logic [6:0] CH_CR    = 7'h0D;

    // Ten to the power n, evaluated at elaboration.
    function automatic longint unsigned pow10(input int n);
        longint unsigned p;
        p = 1;
        for (int k = 0; k < n; k++) begin
            p = p * 10;
        end
        return p;
    endfunction

endpackage

// ===== src/awa_front.sv =====
// Front end: accepts ticks, keeps the sample ring and its running sum, and
// queues the window sum for every report request. Depends on awa_pkg.
module awa_front
    import awa_pkg::*;
#(
    parameter int WINDOW   = WINDOW_DEF,
    parameter int ADC_BITS = ADC_BITS_DEF,
    parameter int SUM_W    = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [SAMPLE_PORT_W-1:0] i_sample,
    input  logic             i_request,
    input  logic             i_q_full,
    output logic             o_q_push,
    output logic [SUM_W-1:0] o_q_sum
);

    localparam int SMP_W = (ADC_BITS < SAMPLE_PORT_W) ? ADC_BITS : SAMPLE_PORT_W;
    localparam int WP_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [SMP_W-1:0] r_ring [WINDOW];
    logic [WP_W-1:0]  r_wpos;
    logic [WP_W-1:0]  n_wpos;
    logic             r_phase;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic [SMP_W-1:0] w_sample;
    logic             w_accept;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_sample = i_sample[SMP_W-1:0];

    // Sum after this tick: on a storing tick the replaced entry leaves and the new sample enters.
    always_comb begin
        n_sum  = r_sum;
        n_wpos = r_wpos;
        if (r_phase) begin
            n_sum = r_sum - SUM_W'(r_ring[r_wpos]) + SUM_W'(w_sample);
            if (r_wpos >= WP_W'(WINDOW - 1)) begin
                n_wpos = '0;
            end else begin
                n_wpos = r_wpos + 1'b1;
            end
        end
    end

    // A report request hands the up-to-date window sum to the queue.
    assign o_q_push = w_accept && i_request;
    assign o_q_sum  = n_sum;

    // Ring, write position, sampling phase and running sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_ring[k] <= '0;
            end
            r_wpos  <= '0;
            r_phase <= 1'b0;
            r_sum   <= '0;
        end else if (w_accept) begin
            r_phase <= !r_phase;
            r_sum   <= n_sum;
            r_wpos  <= n_wpos;
            if (r_phase) begin
                r_ring[r_wpos] <= w_sample;
            end
        end
    end

endmodule

// ===== src/awa_queue.sv =====
// Short FIFO of pending window sums between front end and report engine.
// Depends on awa_pkg.
module awa_queue
    import awa_pkg::*;
#(
    parameter int DATA_W = 20,
    parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Storage is written in place; only the pointers and the fill count need reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== src/awa_back.sv =====
// Report engine: scales a window sum, divides it by decimal compare-and-subtract
// into BCD digits, and streams the ASCII characters. Depends on awa_pkg.
module awa_back
    import awa_pkg::*;
#(
    parameter int WINDOW          = WINDOW_DEF,
    parameter int ADC_BITS        = ADC_BITS_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
    parameter int SUM_W           = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [FS_W-1:0]       i_cfg_wdata,
    input  logic                  i_q_valid,
    input  logic [SUM_W-1:0]      i_q_sum,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_CHAR_W-1:0] o_char,
    output logic                  o_last
);

    localparam longint unsigned MAX_CODE = (64'd1 << ADC_BITS) - 1;
    localparam longint unsigned DIVISOR  = MAX_CODE * WINDOW;
    localparam longint unsigned SCALE    = pow10(FRACTION_DIGITS);
    localparam int SCALE_W = $clog2(SCALE + 1);
    localparam int P1_W    = SUM_W + FS_W;
    localparam int N_W     = P1_W + SCALE_W;
    localparam int NDIG    = INT_DIGITS + FRACTION_DIGITS;
    localparam int BCD_W   = 4 * NDIG;
    localparam int IDX_W   = $clog2(NDIG);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL1  = 8'b0000_0010,
        ST_MUL2  = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_DIG   = 8'b0001_0000,
        ST_POINT = 8'b0010_0000,
        ST_LF    = 8'b0100_0000,
        ST_CR    = 8'b1000_0000
    } t_state;

    // Multiples one to nine of the divisor at every decimal position.
    function automatic logic [NDIG*9*N_W-1:0] mult_table();
        logic [NDIG*9*N_W-1:0] tab;
        tab = '0;
        for (int k = 0; k < NDIG; k++) begin
            for (int j = 0; j < 9; j++) begin
                tab[(k*9 + j)*N_W +: N_W] = N_W'(DIVISOR * pow10(k) * longint'(j + 1));
            end
        end
        return tab;
    endfunction

    localparam logic [NDIG*9*N_W-1:0] MULT_TAB = mult_table();

    t_state              r_state;
    logic [FS_W-1:0]     r_fs;
    logic [FS_W-1:0]     w_fs;
    logic [SUM_W-1:0]    r_sum;
    logic [P1_W-1:0]     r_p1;
    logic [N_W-1:0]      w_n;
    logic [N_W-1:0]      r_rem;
    logic [N_W-1:0]      w_sub;
    logic [3:0]          w_qdig;
    logic [BCD_W-1:0]    r_bcd;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    w_start;
    logic [3:0]          w_digit;
    logic                w_out_free;
    logic                w_emit;
    logic                r_valid;
    logic [OUT_CHAR_W-1:0] r_char;
    logic                r_last;

    // Full-scale register, clamped to three integer digits on use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= FS_RESET;
        end else if (i_cfg_we) begin
            r_fs <= i_cfg_wdata;
        end
    end
    assign w_fs = (r_fs > FS_MAX) ? FS_MAX : r_fs;

    // Second product of the scaled dividend.
    assign w_n = N_W'(r_p1) * N_W'(SCALE);

    // One decimal quotient digit: the largest multiple that still fits.
    always_comb begin
        w_qdig = '0;
        w_sub  = '0;
        for (int j = 0; j < 9; j++) begin
            if (r_rem >= MULT_TAB[(int'(r_idx)*9 + j)*N_W +: N_W]) begin
                w_qdig = 4'(j + 1);
                w_sub  = MULT_TAB[(int'(r_idx)*9 + j)*N_W +: N_W];
            end
        end
    end

    // First printed integer digit: skip leading zeros but keep the units digit.
    always_comb begin
        if (r_bcd[4*(FRACTION_DIGITS+2) +: 4] != 4'd0) begin
            w_start = IDX_W'(FRACTION_DIGITS + 2);
        end else if (r_bcd[4*(FRACTION_DIGITS+1) +: 4] != 4'd0) begin
            w_start = IDX_W'(FRACTION_DIGITS + 1);
        end else begin
            w_start = IDX_W'(FRACTION_DIGITS);
        end
    end

    assign w_digit    = r_bcd[4*r_idx +: 4];
    assign w_out_free = !r_valid || i_ready;
    assign w_emit     = w_out_free && ((r_state == ST_DIG) || (r_state == ST_POINT) ||
                                       (r_state == ST_LF) || (r_state == ST_CR));
    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;

    // Report sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_sum   <= i_q_sum;
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    r_p1    <= P1_W'(r_sum) * P1_W'(w_fs);
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_rem   <= w_n;
                    r_idx   <= IDX_W'(NDIG - 1);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem               <= r_rem - w_sub;
                    r_bcd[4*r_idx +: 4] <= w_qdig;
                    if (r_idx == '0) begin
                        r_idx   <= w_start;
                        r_state <= ST_DIG;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                ST_DIG: begin
                    if (w_out_free) begin
                        r_char  <= CH_ZERO + {3'b000, w_digit};
                        r_last  <= 1'b0;
                        if (r_idx == '0) begin
                            r_state <= ST_LF;
                        end else begin
                            r_idx <= r_idx - 1'b1;
                            if (r_idx == IDX_W'(FRACTION_DIGITS)) begin
                                r_state <= ST_POINT;
                            end
                        end
                    end
                end
                ST_POINT: begin
                    if (w_out_free) begin
                        r_char  <= CH_POINT;
                        r_last  <= 1'b0;
                        r_state <= ST_DIG;
                    end
                end
                ST_LF: begin
                    if (w_out_free) begin
                        r_char  <= CH_LF;
                        r_last  <= 1'b0;
                        r_state <= ST_CR;
                    end
                end
                ST_CR: begin
                    if (w_out_free) begin
                        r_char  <= CH_CR;
                        r_last  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

// ===== src/adc_window_average_ascii_report.sv =====
// Windowed ADC average reported as decimal ASCII text. Every accepted
// transaction is one tick; every second tick stores its sample in a ring of
// WINDOW entries, and a tick with tuser set queues a report of
// sum * full_scale / ((2^ADC_BITS - 1) * WINDOW), truncated to FRACTION_DIGITS
// decimals, sent as integer digits, '.', fraction digits, LF and CR (tlast on
// CR). Ticks are taken one per cycle while the four-entry report queue has
// room. In the engine a report passes the queue pop, two multiplies and one
// compare-and-subtract step per decimal digit before its characters leave one
// per cycle while the receiver is ready, up to eight of them; the next report
// is popped right after the CR is registered, so the conversion steps and the
// character stream with the output handshake together set the report rate.
// Depends on awa_pkg.
module adc_window_average_ascii_report
    import awa_pkg::*;
#(
    parameter int WINDOW          = WINDOW_DEF,
    parameter int ADC_BITS        = ADC_BITS_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [FS_W-1:0]      i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [11:0] adc_sample, rest zero
    input  logic                 s_axis_tuser,  // [0] report_request
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // [6:0] out_char, [7] zero
    output logic                 m_axis_tlast
);

    localparam longint unsigned DIVISOR = ((64'd1 << ADC_BITS) - 1) * WINDOW;
    localparam int SUM_W = $clog2(DIVISOR + 1);

    logic             w_q_push;
    logic [SUM_W-1:0] w_push_sum;
    logic             w_q_full;
    logic             w_q_pop;
    logic             w_q_valid;
    logic [SUM_W-1:0] w_q_sum;
    logic [OUT_CHAR_W-1:0] w_char;

    // Tick intake and sample ring.
    awa_front #(
        .WINDOW   (WINDOW),
        .ADC_BITS (ADC_BITS),
        .SUM_W    (SUM_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_sample  (s_axis_tdata[SAMPLE_PORT_W-1:0]),
        .i_request (s_axis_tuser),
        .i_q_full  (w_q_full),
        .o_q_push  (w_q_push),
        .o_q_sum   (w_push_sum)
    );

    // Pending reports.
    awa_queue #(
        .DATA_W (SUM_W),
        .DEPTH  (QUEUE_DEPTH_DEF)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_push_sum),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_sum)
    );

    // Scaling, conversion and character output.
    awa_back #(
        .WINDOW          (WINDOW),
        .ADC_BITS        (ADC_BITS),
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .SUM_W           (SUM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_sum     (w_q_sum),
        .o_q_pop     (w_q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_char      (w_char),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_char};

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for adc_window_average_ascii_report: stream ticks in,
// check every report character against directed text or a built-in window-average predictor.
// Depends on awa_pkg and the block's RTL only.
module testbench
    import awa_pkg::*;
();

    localparam int              DIR_ROWS    = 24;
    localparam int              PHASES      = 7;
    localparam int              PHASE_TICKS = 54;
    localparam int              CFG_SETTLE  = 40;
    localparam int              END_DRAIN   = 100;
    localparam int              HOLD_CYCLES = 300;
    localparam int              HOLD_AFTER  = 120;
    localparam int              MAX_CYCLES  = 1000000;
    localparam longint unsigned ADC_FULL    = (64'd1 << ADC_BITS_DEF) - 1;
    localparam longint unsigned DEC_SCALE   = 10 ** FRACTION_DIGITS_DEF;

    // One report character as it should leave the block.
    typedef struct packed {
        logic [OUT_CHAR_W-1:0] ch;
        logic                  last;
    } t_report_char;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [FS_W-1:0]      i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;  // [11:0] adc_sample, [15:12] zero
    logic                 s_axis_tuser;  // [0] report_request
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;  // [6:0] out_char, [7] zero
    logic                 m_axis_tlast;

    // Predictor state: sample window, write slot, tick parity, full scale.
    logic [SAMPLE_PORT_W-1:0] win_ring [WINDOW_DEF];
    int                       win_pos;
    bit                       win_phase;
    logic [FS_W-1:0]          full_scale;

    t_report_char report_chars[$];
    int           mismatches;
    int           ticks_accepted;
    int           burst_left;
    longint       cycle_count;

    // Full-scale value per random phase; a negative entry picks one at random.
    int fs_plan [PHASES] = '{999, 1, 1023, 0, -1, 512, -1};

    // Directed table. An empty string means the predictor supplies the text.
    logic [SAMPLE_PORT_W-1:0] dir_sample [DIR_ROWS] = '{
        12'hFFF, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF,
        12'h000, 12'hFFF, 12'h000, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000,
        12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'd50,  12'hFFF, 12'hFFF
    };
    bit dir_req [DIR_ROWS] = '{
        1, 0, 0, 0, 0, 0, 0, 0,
        1, 1, 0, 1, 0, 0, 0, 0,
        0, 0, 0, 1, 0, 1, 0, 1
    };
    string dir_text [DIR_ROWS] = '{
        "0.00", "", "", "", "", "", "", "",
        "32.00", "40.00", "", "32.00", "", "", "", "",
        "", "", "", "0.00", "", "", "", ""
    };

    adc_window_average_ascii_report DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    task automatic note_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    // Offer one tick in a random burst pattern, wait for its transaction, then
    // advance the window and queue the report text it causes.
    task automatic run_tick(input logic [SAMPLE_PORT_W-1:0] sample, input bit req,
                            input string typed);
        int              gap;
        longint unsigned sum;
        longint unsigned fs;
        longint unsigned scaled;
        longint unsigned digit_div;
        string           text;
        byte             c;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-SAMPLE_PORT_W){1'b0}}, sample};
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        ticks_accepted++;

        // Every second tick stores its sample before any report is summed.
        if (win_phase) begin
            win_phase = 1'b0;
            if (win_pos >= WINDOW_DEF) begin
                win_pos = 0;
            end
            win_ring[win_pos] = sample;
            win_pos++;
            if (win_pos >= WINDOW_DEF) begin
                win_pos = 0;
            end
        end else begin
            win_phase = 1'b1;
        end

        if (req) begin
            if (typed != "") begin
                text = typed;
            end else begin
                sum = 0;
                foreach (win_ring[k]) begin
                    sum += win_ring[k];
                end
                fs     = (full_scale > FS_MAX) ? FS_MAX : full_scale;
                scaled = (sum * fs * DEC_SCALE) / (ADC_FULL * WINDOW_DEF);
                text   = $sformatf("%0d", scaled / DEC_SCALE);
                if (FRACTION_DIGITS_DEF > 0) begin
                    text = {text, "."};
                    digit_div = DEC_SCALE;
                    repeat (FRACTION_DIGITS_DEF) begin
                        digit_div = digit_div / 10;
                        text = {text, $sformatf("%0d", (scaled / digit_div) % 10)};
                    end
                end
            end
            for (int k = 0; k < text.len(); k++) begin
                c = text[k];
                report_chars.push_back('{c[6:0], 1'b0});
            end
            report_chars.push_back('{CH_LF, 1'b0});
            report_chars.push_back('{CH_CR, 1'b1});
        end
    endtask

    // Main sequence: reset, directed table, then random phases per full scale.
    initial begin
        int                       phase_start;
        int                       kind;
        logic [SAMPLE_PORT_W-1:0] fill;
        logic [FS_W-1:0]          fs_next;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        foreach (win_ring[k]) begin
            win_ring[k] = '0;
        end
        win_pos        = 0;
        win_phase      = 1'b0;
        full_scale     = FS_RESET;
        mismatches     = 0;
        ticks_accepted = 0;
        burst_left     = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            run_tick(dir_sample[r], dir_req[r], dir_text[r]);
        end

        for (int p = 0; p < PHASES; p++) begin
            // Let the block drain completely before touching the register.
            s_axis_tvalid <= 1'b0;
            while (report_chars.size() != 0) @(posedge i_clk);
            repeat (CFG_SETTLE) @(posedge i_clk);
            fs_next = (fs_plan[p] < 0) ? FS_W'($urandom_range(0, 1023)) : FS_W'(fs_plan[p]);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= fs_next;
            @(posedge i_clk);
            i_cfg_we   <= 1'b0;
            full_scale = fs_next;

            phase_start = ticks_accepted;
            while (ticks_accepted - phase_start < PHASE_TICKS) begin
                kind = $urandom_range(0, 9);
                if (kind < 4) begin
                    // Refill the whole window with one value, then report.
                    case ($urandom_range(0, 3))
                        0: fill = '0;
                        1: fill = '1;
                        2: fill = SAMPLE_PORT_W'($urandom_range(0, 4095));
                        default: fill = SAMPLE_PORT_W'($urandom_range(0, 40));
                    endcase
                    for (int n = 0; n < 2 * WINDOW_DEF; n++) begin
                        run_tick(fill, (n == 2 * WINDOW_DEF - 1) || ($urandom_range(0, 7) == 0),
                                 "");
                    end
                end else begin
                    run_tick(SAMPLE_PORT_W'($urandom_range(0, 4095)),
                             $urandom_range(0, 2) == 0, "");
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (report_chars.size() != 0) @(posedge i_clk);
        repeat (END_DRAIN) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Receiver: random ready patterns, plus one long hold-off that backs the
    // block up until it stalls its input.
    initial begin
        int mode;
        int left;
        bit held;
        mode = 0;
        left = 0;
        held = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && ticks_accepted >= HOLD_AFTER) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 60);
                end
                left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Compare each output transaction with the oldest expected character.
    always @(posedge i_clk) begin : char_check
        t_report_char want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (report_chars.size() == 0) begin
                note_mismatch($sformatf("unexpected char %02h", m_axis_tdata));
            end else begin
                want = report_chars.pop_front();
                if (m_axis_tdata !== {1'b0, want.ch}) begin
                    note_mismatch($sformatf("char %02h, expected %02h",
                                            m_axis_tdata, want.ch));
                end
                if (m_axis_tlast !== want.last) begin
                    note_mismatch($sformatf("tlast %b, expected %b on char %02h",
                                            m_axis_tlast, want.last, want.ch));
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

// ===== adc_window_average_ascii_report.f =====
src/awa_pkg.sv
src/awa_front.sv
src/awa_queue.sv
src/awa_back.sv
src/adc_window_average_ascii_report.sv
dv/testbench.sv
